[src/median_extract_queue_assert.svh]
// assertion macros for the median extract queue checker
`ifndef MEDIAN_EXTRACT_QUEUE_ASSERT_SVH
`define MEDIAN_EXTRACT_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define MEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define MEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/meq_pkg.sv]
// shared constants, codes and types of the median extract queue
package meq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_BITS  = 31;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 31;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 3;
    localparam int CNT_OUT_W = 11;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SERVE  = 2'd1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_SERVED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd4;
    localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd5;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [CNT_W-1:0]    t_cnt;

endpackage

[src/median_extract_queue.sv]
// top level: sorted key store with binary search and one-entry-per-step shifting
//
//  channel  signals                               direction  handshake
//  command  start, i_op, i_key                    in         start & !busy
//  result   o_done, o_status, o_median_key,       out        o_done, one cycle
//           o_entry_count
//
// clear, serve on empty: result in the cycle after the item
// insert: s search steps (SQ_SRCH, SQ_CMP), s about log2(count)+1; a duplicate or
//   full store ends there, else SQ_INS_RD/SQ_INS_WR per key moved up, then SQ_PUT
// serve: SQ_SRV, then SQ_DEL_RD/SQ_DEL_WR per key moved down behind the median
// reset is synchronous; ram contents are left as is, only state, count and done clear
// results cannot be held off, busy covers each operation that leaves the idle state
module median_extract_queue
    import meq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      i_op,
    input  logic [KEY_W-1:0]     i_key,
    output logic                 o_done,
    output logic [STAT_W-1:0]    o_status,
    output logic [KEY_W-1:0]     o_median_key,
    output logic [CNT_OUT_W-1:0] o_entry_count
);

    localparam logic [3:0] SQ_IDLE   = 4'd0;
    localparam logic [3:0] SQ_SRCH   = 4'd1;
    localparam logic [3:0] SQ_CMP    = 4'd2;
    localparam logic [3:0] SQ_INS_RD = 4'd3;
    localparam logic [3:0] SQ_INS_WR = 4'd4;
    localparam logic [3:0] SQ_PUT    = 4'd5;
    localparam logic [3:0] SQ_SRV    = 4'd6;
    localparam logic [3:0] SQ_DEL_RD = 4'd7;
    localparam logic [3:0] SQ_DEL_WR = 4'd8;

    logic [3:0]        r_state, n_state;
    t_cnt              r_count, n_count;
    t_cnt              r_lo, n_lo;
    t_cnt              r_hi, n_hi;
    logic              r_eqh, n_eqh;
    t_addr             r_mid, n_mid;
    t_addr             r_ptr, n_ptr;
    t_key              r_key, n_key;
    logic              r_done, n_done;
    logic [STAT_W-1:0] r_status, n_status;
    t_key              r_mkey, n_mkey;

    logic  we;
    t_addr waddr;
    t_key  wdata;
    t_addr raddr;
    t_key  rdata;
    t_cnt  mid_full;
    t_cnt  cnt_m1;

    meq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign mid_full = r_lo + ((r_hi - r_lo) >> 1);
    assign cnt_m1   = r_count - CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_eqh    = r_eqh;
        n_mid    = r_mid;
        n_ptr    = r_ptr;
        n_key    = r_key;
        n_done   = 1'b0;
        n_status = r_status;
        n_mkey   = r_mkey;
        we       = 1'b0;
        waddr    = r_ptr;
        wdata    = rdata;
        raddr    = r_mid;

        unique case (r_state)
            SQ_IDLE: begin
                // median index (count+1)/2-1 read ahead for a serve
                raddr = ADDR_W'(cnt_m1 >> 1);
                if (start) begin
                    n_key  = KEY_BITS'(i_key);
                    n_mkey = '0;
                    priority if (i_op == OP_INSERT) begin
                        n_lo    = '0;
                        n_hi    = r_count;
                        n_eqh   = 1'b0;
                        n_state = SQ_SRCH;
                    end else if (i_op == OP_SERVE) begin
                        if (r_count == '0) begin
                            n_done   = 1'b1;
                            n_status = ST_EMPTY;
                        end else begin
                            n_ptr   = ADDR_W'(cnt_m1 >> 1);
                            n_state = SQ_SRV;
                        end
                    end else begin
                        n_count  = '0;
                        n_done   = 1'b1;
                        n_status = ST_CLEARED;
                    end
                end
            end
            SQ_SRCH: begin
                raddr = ADDR_W'(mid_full);
                if (r_lo < r_hi) begin
                    n_mid   = ADDR_W'(mid_full);
                    n_state = SQ_CMP;
                end else if (r_eqh) begin
                    n_done   = 1'b1;
                    n_status = ST_DUP;
                    n_state  = SQ_IDLE;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    n_done   = 1'b1;
                    n_status = ST_FULL;
                    n_state  = SQ_IDLE;
                end else begin
                    // r_lo is the insert position from here on
                    n_ptr   = ADDR_W'(r_count);
                    n_state = (r_lo == r_count) ? SQ_PUT : SQ_INS_RD;
                end
            end
            SQ_CMP: begin
                if (rdata < r_key) begin
                    n_lo = CNT_W'(r_mid) + CNT_W'(1);
                end else begin
                    n_hi  = CNT_W'(r_mid);
                    n_eqh = (rdata == r_key);
                end
                n_state = SQ_SRCH;
            end
            SQ_INS_RD: begin
                raddr   = r_ptr - ADDR_W'(1);
                n_state = SQ_INS_WR;
            end
            SQ_INS_WR: begin
                we      = 1'b1;
                waddr   = r_ptr;
                wdata   = rdata;
                n_ptr   = r_ptr - ADDR_W'(1);
                n_state = (CNT_W'(n_ptr) == r_lo) ? SQ_PUT : SQ_INS_RD;
            end
            SQ_PUT: begin
                we       = 1'b1;
                waddr    = ADDR_W'(r_lo);
                wdata    = r_key;
                n_count  = r_count + CNT_W'(1);
                n_done   = 1'b1;
                n_status = ST_INSERTED;
                n_state  = SQ_IDLE;
            end
            SQ_SRV: begin
                n_mkey = rdata;
                if (CNT_W'(r_ptr) == cnt_m1) begin
                    n_count  = cnt_m1;
                    n_done   = 1'b1;
                    n_status = ST_SERVED;
                    n_state  = SQ_IDLE;
                end else begin
                    n_state = SQ_DEL_RD;
                end
            end
            SQ_DEL_RD: begin
                raddr   = r_ptr + ADDR_W'(1);
                n_state = SQ_DEL_WR;
            end
            SQ_DEL_WR: begin
                we    = 1'b1;
                waddr = r_ptr;
                wdata = rdata;
                n_ptr = r_ptr + ADDR_W'(1);
                if (CNT_W'(n_ptr) == cnt_m1) begin
                    n_count  = cnt_m1;
                    n_done   = 1'b1;
                    n_status = ST_SERVED;
                    n_state  = SQ_IDLE;
                end else begin
                    n_state = SQ_DEL_RD;
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_eqh    <= n_eqh;
        r_mid    <= n_mid;
        r_ptr    <= n_ptr;
        r_key    <= n_key;
        r_status <= n_status;
        r_mkey   <= n_mkey;
    end

    assign busy          = (r_state != SQ_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_median_key  = KEY_W'(r_mkey);
    assign o_entry_count = CNT_OUT_W'(r_count);

endmodule

[src/meq_ram.sv]
// simple dual port ram, one write and one registered read per cycle
module meq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/meq_checker.sv]
// port-level checker for the median extract queue, bound to the top level
`include "median_extract_queue_assert.svh"

module meq_checker
    import meq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_done,
    input logic [STAT_W-1:0]    o_status,
    input logic [KEY_W-1:0]     o_median_key,
    input logic [CNT_OUT_W-1:0] o_entry_count
);

    // an accepted item either finishes next cycle or holds busy
    `MEQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || o_done, "item lost after accept")

    // a multi-cycle operation always ends with a result
    `MEQ_ASSERT_NOW(a_busy_end_result, $fell(busy), o_done, "busy dropped without result")

    // empty serve and clear leave nothing held
    `MEQ_ASSERT_NOW(a_empty_count, o_done && (o_status == ST_EMPTY || o_status == ST_CLEARED), o_entry_count == '0, "count not zero after empty or clear")

    // only a served item carries a key
    `MEQ_ASSERT_NOW(a_key_only_served, o_done && o_status != ST_SERVED, o_median_key == '0, "key shown without serve")

endmodule

bind median_extract_queue meq_checker u_meq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_median_key  (o_median_key),
    .o_entry_count (o_entry_count)
);
